@@ rtl/fbp_pkg.sv @@
// Shared types and constants for the border-passthrough FIR filter.
`timescale 1ns / 1ps

package fbp_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_WIDTH     = 16;
    localparam int COEF_FRAC_BITS = 12;
    localparam int MAX_TAPS       = 7;
    localparam int TAP_IDX_W      = $clog2(MAX_TAPS);
    localparam int HW_WIDTH       = 2;
    localparam int NUM_TAIL       = 3;
    localparam int TAIL_CNT_W     = 2;
    localparam int SEEN_W         = 3;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int PROD_WIDTH     = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int PAIR_WIDTH     = PROD_WIDTH + 1;
    localparam int ACC_WIDTH      = PROD_WIDTH + 3;
    localparam int QUOT_WIDTH     = ACC_WIDTH - COEF_FRAC_BITS;

    localparam logic [SEEN_W-1:0]    SEEN_MAX       = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BASE  = 3'd1;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [COEF_WIDTH-1:0]   coef_t;

    typedef enum logic [1:0] {
        MAIN_NONE,
        MAIN_RAW,
        MAIN_FILT
    } main_kind_t;

    // Classified item as it leaves the front end.
    typedef struct packed {
        main_kind_t                    kind;
        sample_t                       raw;
        logic [TAIL_CNT_W-1:0]         tail_cnt;
        sample_t [NUM_TAIL-1:0]        tail;
        logic                          last;
        sample_t [MAX_TAPS-1:0]        win;
    } qentry_t;

    // Finished item ready to be serialized into output words.
    typedef struct packed {
        logic                          main_valid;
        sample_t                       main_val;
        logic [TAIL_CNT_W-1:0]         tail_cnt;
        sample_t [NUM_TAIL-1:0]        tail;
        logic                          last;
    } emit_t;

endpackage

@@ rtl/fbp_front.sv @@
// Front end: accepts samples, keeps the delay line and classifies each item.
`timescale 1ns / 1ps

module fbp_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fbp_pkg::SAMPLE_WIDTH-1:0] s_tdata,
    input  logic                            s_tlast,
    input  logic [fbp_pkg::HW_WIDTH-1:0]    half_width,
    input  logic                            q_full,
    output logic                            push,
    output fbp_pkg::qentry_t                push_data
);
    import fbp_pkg::*;

    sample_t                delay_line_reg [MAX_TAPS];
    sample_t                dl_next        [MAX_TAPS];
    logic [SEEN_W-1:0]      seen_reg;
    logic [SEEN_W-1:0]      seen_next;
    logic [TAP_IDX_W-1:0]   two_h;
    logic [TAP_IDX_W-1:0]   h_ext;
    logic                   filt;
    logic                   raw_ok;
    logic [TAIL_CNT_W-1:0]  start;
    logic                   accept;
    qentry_t                entry;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign two_h    = {half_width, 1'b0};
    assign h_ext    = {1'b0, half_width};
    assign filt     = seen_reg >= two_h;
    assign raw_ok   = seen_reg >= h_ext;

    always_comb
    begin
        dl_next[0] = sample_t'(s_tdata);
        for (int i = 1; i < MAX_TAPS; i++)
        begin
            dl_next[i] = delay_line_reg[i-1];
        end
    end

    // Tail words run from the oldest still-pending position down to the newest sample.
    assign start = raw_ok ? (half_width - 2'd1) : seen_reg[TAIL_CNT_W-1:0];

    always_comb
    begin
        entry      = '0;
        entry.last = s_tlast;
        entry.raw  = dl_next[h_ext];
        if (filt)
        begin
            entry.kind = MAIN_FILT;
        end
        else if (raw_ok)
        begin
            entry.kind = MAIN_RAW;
        end
        else
        begin
            entry.kind = MAIN_NONE;
        end
        if (s_tlast)
        begin
            entry.tail_cnt = raw_ok ? half_width : (seen_reg[TAIL_CNT_W-1:0] + 2'd1);
        end
        for (int k = 0; k < NUM_TAIL; k++)
        begin
            if (TAIL_CNT_W'(k) < entry.tail_cnt)
            begin
                entry.tail[k] = dl_next[{1'b0, start - TAIL_CNT_W'(k)}];
            end
        end
        for (int t = 0; t < MAX_TAPS; t++)
        begin
            if (TAP_IDX_W'(t) <= two_h)
            begin
                entry.win[t] = dl_next[two_h - TAP_IDX_W'(t)];
            end
        end
    end

    // An item produces a word when its centre is reached or when it closes the series.
    assign push      = accept && (raw_ok || s_tlast);
    assign push_data = entry;

    always_comb
    begin
        if (s_tlast)
        begin
            seen_next = '0;
        end
        else if (seen_reg < SEEN_MAX)
        begin
            seen_next = seen_reg + 3'd1;
        end
        else
        begin
            seen_next = seen_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                delay_line_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            seen_reg <= seen_next;
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                delay_line_reg[i] <= dl_next[i];
            end
        end
    end

endmodule

@@ rtl/fbp_queue.sv @@
// Short register FIFO between the front end and the arithmetic back end.
`timescale 1ns / 1ps

module fbp_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  fbp_pkg::qentry_t push_data,
    input  logic             pop,
    output fbp_pkg::qentry_t head,
    output logic             not_empty,
    output logic             full
);
    import fbp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    qentry_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule

@@ rtl/fbp_mac.sv @@
// Back-end arithmetic: tap products, adder tree, round-half-even and saturation.
`timescale 1ns / 1ps

module fbp_mac
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  fbp_pkg::qentry_t                      in_data,
    input  fbp_pkg::coef_t [fbp_pkg::MAX_TAPS-1:0] coefs,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output fbp_pkg::emit_t                        out_data
);
    import fbp_pkg::*;

    localparam int NUM_PAIRS = (MAX_TAPS + 1) / 2;
    localparam logic [COEF_FRAC_BITS-1:0] HALF_LSB = {1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
    localparam logic signed [QUOT_WIDTH:0] SAT_HI = (QUOT_WIDTH+1)'((1 << (SAMPLE_WIDTH-1)) - 1);
    localparam logic signed [QUOT_WIDTH:0] SAT_LO = -SAT_HI - (QUOT_WIDTH+1)'(1);

    // Stage 1: products.
    logic                          s1_valid_reg;
    qentry_t                       s1_job_reg;
    logic signed [PROD_WIDTH-1:0]  s1_prod_reg [MAX_TAPS];
    // Stage 2: pairwise sums.
    logic                          s2_valid_reg;
    qentry_t                       s2_job_reg;
    logic signed [PAIR_WIDTH-1:0]  s2_pair_reg [NUM_PAIRS];
    // Stage 3: full sum.
    logic                          s3_valid_reg;
    qentry_t                       s3_job_reg;
    logic signed [ACC_WIDTH-1:0]   s3_acc_reg;
    logic signed [ACC_WIDTH-1:0]   acc_next;
    // Stage 4: rounded result.
    logic                          out_valid_reg;
    emit_t                         out_data_reg;
    emit_t                         out_next;

    logic                          r1;
    logic                          r2;
    logic                          r3;
    logic                          r4;
    logic signed [QUOT_WIDTH-1:0]  quot;
    logic [COEF_FRAC_BITS-1:0]     frac;
    logic                          round_up;
    logic signed [QUOT_WIDTH:0]    rounded;
    sample_t                       sat_val;

    assign r4       = !out_valid_reg || out_ready;
    assign r3       = !s3_valid_reg || r4;
    assign r2       = !s2_valid_reg || r3;
    assign r1       = !s1_valid_reg || r2;
    assign in_ready = r1;

    always_comb
    begin
        acc_next = '0;
        for (int p = 0; p < NUM_PAIRS; p++)
        begin
            acc_next = acc_next + ACC_WIDTH'(s2_pair_reg[p]);
        end
    end

    // Floor quotient plus a round-half-even correction on the dropped fraction.
    assign quot     = s3_acc_reg[ACC_WIDTH-1:COEF_FRAC_BITS];
    assign frac     = s3_acc_reg[COEF_FRAC_BITS-1:0];
    assign round_up = (frac > HALF_LSB) || ((frac == HALF_LSB) && quot[0]);
    assign rounded  = (QUOT_WIDTH+1)'(quot) + (QUOT_WIDTH+1)'($signed({1'b0, round_up}));

    always_comb
    begin
        if (rounded > SAT_HI)
        begin
            sat_val = SAT_HI[SAMPLE_WIDTH-1:0];
        end
        else if (rounded < SAT_LO)
        begin
            sat_val = SAT_LO[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            sat_val = rounded[SAMPLE_WIDTH-1:0];
        end
    end

    always_comb
    begin
        out_next            = '0;
        out_next.main_valid = s3_job_reg.kind != MAIN_NONE;
        out_next.main_val   = (s3_job_reg.kind == MAIN_FILT) ? sat_val : s3_job_reg.raw;
        out_next.tail_cnt   = s3_job_reg.tail_cnt;
        out_next.tail       = s3_job_reg.tail;
        out_next.last       = s3_job_reg.last;
    end

    always_ff @(posedge clk)
    begin
        if (r1 && in_valid)
        begin
            s1_job_reg <= in_data;
            for (int t = 0; t < MAX_TAPS; t++)
            begin
                s1_prod_reg[t] <= $signed(in_data.win[t]) * $signed(coefs[t]);
            end
        end
        if (r2 && s1_valid_reg)
        begin
            s2_job_reg <= s1_job_reg;
            for (int p = 0; p < NUM_PAIRS; p++)
            begin
                if (2 * p + 1 < MAX_TAPS)
                begin
                    s2_pair_reg[p] <= PAIR_WIDTH'(s1_prod_reg[2*p])
                                    + PAIR_WIDTH'(s1_prod_reg[2*p+1]);
                end
                else
                begin
                    s2_pair_reg[p] <= PAIR_WIDTH'(s1_prod_reg[2*p]);
                end
            end
        end
        if (r3 && s2_valid_reg)
        begin
            s3_job_reg <= s2_job_reg;
            s3_acc_reg <= acc_next;
        end
        if (r4 && s3_valid_reg)
        begin
            out_data_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (r2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (r3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (r4)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/fbp_emit.sv @@
// Back-end sequencer: turns each finished item into one to four output words.
`timescale 1ns / 1ps

module fbp_emit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  fbp_pkg::emit_t                   in_data,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fbp_pkg::SAMPLE_WIDTH-1:0] m_tdata,
    output logic                             m_tlast
);
    import fbp_pkg::*;

    logic [TAIL_CNT_W-1:0]   pos_reg;
    logic [TAIL_CNT_W-1:0]   pos_next;
    logic                    m_valid_reg;
    logic                    m_valid_next;
    sample_t                 m_data_reg;
    logic                    m_last_reg;
    logic                    load;
    logic [TAIL_CNT_W:0]     word_cnt;
    logic                    is_final;
    logic [TAIL_CNT_W-1:0]   tidx;
    sample_t                 word;

    assign load     = !m_valid_reg || m_tready;
    assign word_cnt = {{TAIL_CNT_W{1'b0}}, in_data.main_valid} + {1'b0, in_data.tail_cnt};
    assign is_final = ({1'b0, pos_reg} + (TAIL_CNT_W+1)'(1)) == word_cnt;
    assign tidx     = pos_reg - {{(TAIL_CNT_W-1){1'b0}}, in_data.main_valid};
    assign in_ready = load && in_valid && is_final;

    always_comb
    begin
        if (in_data.main_valid && (pos_reg == '0))
        begin
            word = in_data.main_val;
        end
        else
        begin
            case (tidx)
                2'd0:    word = in_data.tail[0];
                2'd1:    word = in_data.tail[1];
                2'd2:    word = in_data.tail[2];
                default: word = '0;
            endcase
        end
    end

    always_comb
    begin
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg;
        if (load)
        begin
            m_valid_next = in_valid;
            if (in_valid)
            begin
                pos_next = is_final ? '0 : pos_reg + TAIL_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            m_data_reg <= word;
            m_last_reg <= in_data.last && is_final;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

@@ rtl/fir_filter_border_passthrough_unit.sv @@
// Top level of the symmetric-window FIR with raw passthrough at the series borders.
// Words reach m_tdata through the queue, the MAC stages and the sequencer's output register.
// Throughput: one sample per cycle; a sample that closes a series yields up to four words,
// one per cycle from the sequencer while m_tready holds; only a full queue stalls the front.
// Reset clears the delay line, the series count, the queue and all pipeline valids;
// half_width resets to 1 and coef_1 to 1.0 (4096), the other weights to zero.
`timescale 1ns / 1ps

module fir_filter_border_passthrough_unit
#(
    parameter int QUEUE_DEPTH = 4    // front-to-back queue entries, 2 or more
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port: index 0 is half_width, 1..7 are coef_0..coef_6.
    input  logic                             cfg_we,
    input  logic [fbp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fbp_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Input stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [fbp_pkg::SAMPLE_WIDTH-1:0] s_tdata,   // [15:0] sample
    input  logic                             s_tlast,   // last_in
    // Output stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fbp_pkg::SAMPLE_WIDTH-1:0] m_tdata,   // [15:0] filtered
    output logic                             m_tlast    // last_out
);
    import fbp_pkg::*;

    logic [HW_WIDTH-1:0]        half_width_reg;
    coef_t [MAX_TAPS-1:0]       coef_reg;
    logic                       q_full;
    logic                       q_not_empty;
    logic                       q_push;
    logic                       q_pop;
    qentry_t                    q_push_data;
    qentry_t                    q_head;
    logic                       mac_valid;
    logic                       mac_ready;
    emit_t                      mac_data;

    // Configuration registers. Users must write only while the datapath is idle (the block
    // does not enforce it); every stage reads them directly, without shadow copies.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg <= HW_WIDTH'(1);
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                coef_reg[i] <= (i == 1) ? coef_t'(1 << COEF_FRAC_BITS) : coef_t'(0);
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_HALF_WIDTH)
            begin
                half_width_reg <= cfg_data[HW_WIDTH-1:0];
            end
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                if (cfg_index == REG_COEF_BASE + CFG_IDX_W'(i))
                begin
                    coef_reg[i] <= coef_t'(cfg_data);
                end
            end
        end
    end

    // The front end shifts the delay line and decides, per sample, whether it
    // emits a filtered word, a raw border word, and how many tail words flush.
    fbp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .half_width (half_width_reg),
        .q_full     (q_full),
        .push       (q_push),
        .push_data  (q_push_data)
    );

    fbp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    // The back end: a four-stage elastic multiply-accumulate pipeline feeding
    // the word sequencer, which owns the output register.
    fbp_mac u_mac
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_not_empty),
        .in_ready  (q_pop),
        .in_data   (q_head),
        .coefs     (coef_reg),
        .out_valid (mac_valid),
        .out_ready (mac_ready),
        .out_data  (mac_data)
    );

    fbp_emit u_emit
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (mac_valid),
        .in_ready (mac_ready),
        .in_data  (mac_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
